// ----- src/c2pa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package c2pa_pkg;

  localparam int COMPONENT_WIDTH_DEF = 32;
  localparam int ANGLE_FRAC_BITS_DEF = 8;
  localparam int CORDIC_STAGES_DEF   = 20;

  // datapath width of the rotators and angle accumulator width
  localparam int DW            = 64;
  localparam int ACC_W         = 36;
  localparam int ACC_FRAC      = 24;
  localparam int NORM_TOP      = 57;
  localparam int SHW           = 6;
  localparam int POLAR_WIDTH   = 16;
  localparam int AZIMUTH_WIDTH = 17;
  localparam int TOL_W         = 8;

  localparam logic [29:0] INV_GAIN = 30'd652032874;

  localparam logic signed [ACC_W-1:0] DEG90  = 36'sd1509949440;
  localparam logic signed [ACC_W-1:0] DEG180 = 36'sd3019898880;
  localparam logic signed [ACC_W-1:0] DEG360 = 36'sd6039797760;

  typedef struct packed {
    logic signed [DW-1:0]    x;
    logic signed [DW-1:0]    y;
    logic signed [ACC_W-1:0] acc;
  } cordic_t;

  // sideband through the azimuth pass
  typedef struct packed {
    logic signed [DW-1:0] z;
    logic                 axis;
    logic                 zero;
  } side_phi_t;

  // sideband through the polar pass
  typedef struct packed {
    logic [AZIMUTH_WIDTH-1:0] phi;
    logic                     zero;
  } side_theta_t;

  // atan(2^-idx) in degrees, 24 fraction bits
  function automatic logic signed [ACC_W-1:0] atan_deg(input int idx);
    logic signed [ACC_W-1:0] v;
    case (idx)
      0:  v = 36'sd754974720;
      1:  v = 36'sd445687602;
      2:  v = 36'sd235489088;
      3:  v = 36'sd119537938;
      4:  v = 36'sd60000934;
      5:  v = 36'sd30029717;
      6:  v = 36'sd15018523;
      7:  v = 36'sd7509720;
      8:  v = 36'sd3754917;
      9:  v = 36'sd1877466;
      10: v = 36'sd938734;
      11: v = 36'sd469367;
      12: v = 36'sd234684;
      13: v = 36'sd117342;
      14: v = 36'sd58671;
      15: v = 36'sd29335;
      16: v = 36'sd14668;
      17: v = 36'sd7334;
      18: v = 36'sd3667;
      19: v = 36'sd1833;
      20: v = 36'sd917;
      21: v = 36'sd458;
      22: v = 36'sd229;
      23: v = 36'sd115;
      24: v = 36'sd57;
      25: v = 36'sd29;
      26: v = 36'sd14;
      27: v = 36'sd7;
      28: v = 36'sd4;
      29: v = 36'sd2;
      30: v = 36'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- src/c2pa_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface c2pa_vec_if #(
  parameter int CW = c2pa_pkg::COMPONENT_WIDTH_DEF
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] vec_x;
  logic signed [CW-1:0] vec_y;
  logic signed [CW-1:0] vec_z;
  modport source (output valid, vec_x, vec_y, vec_z, input ready);
  modport sink   (input valid, vec_x, vec_y, vec_z, output ready);
endinterface

interface c2pa_res_if;
  logic                                   valid;
  logic                                   ready;
  logic [c2pa_pkg::POLAR_WIDTH-1:0]       polar_angle;
  logic [c2pa_pkg::AZIMUTH_WIDTH-1:0]     azimuth_angle;
  modport source (output valid, polar_angle, azimuth_angle, input ready);
  modport sink   (input valid, polar_angle, azimuth_angle, output ready);
endinterface

interface c2pa_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [c2pa_pkg::TOL_W-1:0]  pole_tolerance;
  modport source (output valid, pole_tolerance, input ready);
  modport sink   (input valid, pole_tolerance, output ready);
endinterface
`default_nettype wire

// ----- src/c2pa_norm.sv -----
`timescale 1ns / 1ps
`default_nettype none
module c2pa_norm #(
  parameter int CW = c2pa_pkg::COMPONENT_WIDTH_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 vld_i,
  output logic                      rdy_o,
  input  wire logic signed [CW-1:0] x_i,
  input  wire logic signed [CW-1:0] y_i,
  input  wire logic signed [CW-1:0] z_i,
  output logic                      vld_o,
  input  wire logic                 rdy_i,
  output c2pa_pkg::cordic_t         st_o,
  output c2pa_pkg::side_phi_t       sb_o
);
  import c2pa_pkg::*;

  localparam int NG = (CW + 7) / 8;

  logic en1, en2, en3, en4;
  logic v1_q, v2_q, v3_q, v4_q;

  // stage 1: magnitudes
  logic [CW-1:0] mx_d, my_d, mz_d, mx1_q, my1_q, mz1_q;
  logic          nx1_q, ny1_q, nz1_q, axis1_q;
  logic [CW-1:0] mor1_q;

  // stage 2: per-byte leading one
  logic [CW-1:0] mx2_q, my2_q, mz2_q;
  logic          nx2_q, ny2_q, nz2_q, axis2_q;
  logic [NG-1:0] gnz_d, gnz_q;
  logic [2:0]    gpos_d [NG], gpos_q [NG];
  logic [NG*8-1:0] mor_pad;

  // stage 3: shift amount
  logic [CW-1:0]  mx3_q, my3_q, mz3_q;
  logic           nx3_q, ny3_q, nz3_q, axis3_q, zero3_q;
  logic [SHW-1:0] s_d, s_q;

  // stage 4: shifted vector
  logic [DW-1:0] xs, ys, zs;
  cordic_t       st_d, st_q;
  side_phi_t     sb_d, sb_q;

  assign en4   = !v4_q || rdy_i;
  assign en3   = !v3_q || en4;
  assign en2   = !v2_q || en3;
  assign en1   = !v1_q || en2;
  assign rdy_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= vld_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  assign mx_d = x_i[CW-1] ? (~x_i + 1'b1) : x_i;
  assign my_d = y_i[CW-1] ? (~y_i + 1'b1) : y_i;
  assign mz_d = z_i[CW-1] ? (~z_i + 1'b1) : z_i;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      mx1_q   <= mx_d;
      my1_q   <= my_d;
      mz1_q   <= mz_d;
      nx1_q   <= x_i[CW-1];
      ny1_q   <= y_i[CW-1];
      nz1_q   <= z_i[CW-1];
      axis1_q <= (x_i == '0) && (y_i == '0);
      // top one of the OR is the top one of the largest magnitude
      mor1_q  <= mx_d | my_d | mz_d;
    end
  end

  always_comb begin
    mor_pad = '0;
    mor_pad[CW-1:0] = mor1_q;
    for (int g = 0; g < NG; g++) begin
      gnz_d[g]  = |mor_pad[g*8 +: 8];
      gpos_d[g] = '0;
      for (int b = 0; b < 8; b++) begin
        if (mor_pad[g*8+b]) gpos_d[g] = 3'(b);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      mx2_q   <= mx1_q;
      my2_q   <= my1_q;
      mz2_q   <= mz1_q;
      nx2_q   <= nx1_q;
      ny2_q   <= ny1_q;
      nz2_q   <= nz1_q;
      axis2_q <= axis1_q;
      gnz_q   <= gnz_d;
      gpos_q  <= gpos_d;
    end
  end

  always_comb begin
    s_d = '0;
    for (int g = 0; g < NG; g++) begin
      if (gnz_q[g]) s_d = SHW'(NORM_TOP - (g * 8 + int'(gpos_q[g])));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      mx3_q   <= mx2_q;
      my3_q   <= my2_q;
      mz3_q   <= mz2_q;
      nx3_q   <= nx2_q;
      ny3_q   <= ny2_q;
      nz3_q   <= nz2_q;
      axis3_q <= axis2_q;
      zero3_q <= ~|gnz_q;
      s_q     <= s_d;
    end
  end

  // negative x: rotate by 180 degrees up front, so x stays the magnitude
  always_comb begin
    xs       = DW'(mx3_q) << s_q;
    ys       = DW'(my3_q) << s_q;
    zs       = DW'(mz3_q) << s_q;
    st_d.x   = xs;
    st_d.y   = (ny3_q ^ nx3_q) ? -ys : ys;
    st_d.acc = nx3_q ? DEG180 : '0;
    sb_d.z    = nz3_q ? -zs : zs;
    sb_d.axis = axis3_q;
    sb_d.zero = zero3_q;
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      st_q <= st_d;
      sb_q <= sb_d;
    end
  end

  assign vld_o = v4_q;
  assign st_o  = st_q;
  assign sb_o  = sb_q;

endmodule
`default_nettype wire

// ----- src/c2pa_cordic_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none
module c2pa_cordic_stage #(
  parameter int IDX  = 0,
  parameter int SB_W = 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              vld_i,
  output logic                   rdy_o,
  input  wire c2pa_pkg::cordic_t st_i,
  input  wire logic [SB_W-1:0]   sb_i,
  output logic                   vld_o,
  input  wire logic              rdy_i,
  output c2pa_pkg::cordic_t      st_o,
  output logic [SB_W-1:0]        sb_o
);
  import c2pa_pkg::*;

  logic signed [DW-1:0]    x, y, dx, dy;
  logic signed [ACC_W-1:0] at;
  logic                    en, vld_q;
  cordic_t                 st_d, st_q;
  logic [SB_W-1:0]         sb_q;

  assign x  = st_i.x;
  assign y  = st_i.y;
  assign dx = y >>> IDX;
  assign dy = x >>> IDX;
  assign at = atan_deg(IDX);
  assign en = !vld_q || rdy_i;
  assign rdy_o = en;

  always_comb begin
    if (!y[DW-1] && (y != '0)) begin
      st_d.x   = x + dx;
      st_d.y   = y - dy;
      st_d.acc = st_i.acc + at;
    end else begin
      st_d.x   = x - dx;
      st_d.y   = y + dy;
      st_d.acc = st_i.acc - at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st_q <= st_d;
      sb_q <= sb_i;
    end
  end

  assign vld_o = vld_q;
  assign st_o  = st_q;
  assign sb_o  = sb_q;

endmodule
`default_nettype wire

// ----- src/c2pa_gain.sv -----
`timescale 1ns / 1ps
`default_nettype none
module c2pa_gain #(
  parameter int AFB = c2pa_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                vld_i,
  output logic                     rdy_o,
  input  wire c2pa_pkg::cordic_t   st_i,
  input  wire c2pa_pkg::side_phi_t sb_i,
  output logic                     vld_o,
  input  wire logic                rdy_i,
  output c2pa_pkg::cordic_t        st_o,
  output c2pa_pkg::side_theta_t    sb_o
);
  import c2pa_pkg::*;

  localparam int SH = ACC_FRAC - AFB;
  localparam logic [ACC_W-1:0] RND       = ACC_W'(1) << (SH - 1);
  localparam logic [ACC_W-1:0] FULL_TURN = ACC_W'(360) << AFB;

  logic en1, en2, v1_q, v2_q;

  logic [DW-1:0]            mag;
  logic signed [ACC_W-1:0]  acc_w;
  logic [ACC_W-1:0]         phi_r;
  logic [AZIMUTH_WIDTH-1:0] phi_d, phi_q;
  logic [59:0]              p_hi_d, p_lo_d, p_hi_q, p_lo_q;
  logic signed [DW-1:0]     z_q;
  logic                     zero_q;
  logic [DW-1:0]            r;
  cordic_t                  st_d, st_q;
  side_theta_t              sb_q;

  assign en2   = !v2_q || rdy_i;
  assign en1   = !v1_q || en2;
  assign rdy_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) v1_q <= vld_i;
      if (en2) v2_q <= v1_q;
    end
  end

  // finish azimuth, multiply both 30-bit halves of the magnitude by the inverse gain
  always_comb begin
    mag    = st_i.x;
    acc_w  = st_i.acc[ACC_W-1] ? st_i.acc + DEG360 : st_i.acc;
    phi_r  = (ACC_W'(acc_w) + RND) >> SH;
    if ((phi_r >= FULL_TURN) || sb_i.axis) phi_d = '0;
    else phi_d = AZIMUTH_WIDTH'(phi_r);
    p_hi_d = mag[59:30] * INV_GAIN;
    p_lo_d = mag[29:0] * INV_GAIN;
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      phi_q  <= phi_d;
      p_hi_q <= p_hi_d;
      p_lo_q <= p_lo_d;
      z_q    <= sb_i.z;
      zero_q <= sb_i.zero;
    end
  end

  // negative z: start the polar pass rotated by -90 degrees
  always_comb begin
    r = DW'(p_hi_q) + DW'(p_lo_q[59:30]);
    if (z_q[DW-1]) begin
      st_d.x   = r;
      st_d.y   = -z_q;
      st_d.acc = DEG90;
    end else begin
      st_d.x   = z_q;
      st_d.y   = r;
      st_d.acc = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      st_q     <= st_d;
      sb_q.phi  <= phi_q;
      sb_q.zero <= zero_q;
    end
  end

  assign vld_o = v2_q;
  assign st_o  = st_q;
  assign sb_o  = sb_q;

endmodule
`default_nettype wire

// ----- src/c2pa_finish.sv -----
`timescale 1ns / 1ps
`default_nettype none
module c2pa_finish #(
  parameter int AFB = c2pa_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  vld_i,
  output logic                                       rdy_o,
  input  wire c2pa_pkg::cordic_t                     st_i,
  input  wire c2pa_pkg::side_theta_t                 sb_i,
  input  wire logic [c2pa_pkg::TOL_W-1:0]            tol_i,
  output logic                                       vld_o,
  input  wire logic                                  rdy_i,
  output logic [c2pa_pkg::POLAR_WIDTH-1:0]           polar_o,
  output logic [c2pa_pkg::AZIMUTH_WIDTH-1:0]         azimuth_o
);
  import c2pa_pkg::*;

  localparam int SH = ACC_FRAC - AFB;
  localparam logic [ACC_W-1:0] RND     = ACC_W'(1) << (SH - 1);
  localparam logic [ACC_W-1:0] HALF    = ACC_W'(180) << AFB;
  localparam logic [ACC_W-1:0] QUARTER = ACC_W'(90) << AFB;

  logic en1, en2, v1_q, v2_q;

  logic signed [ACC_W-1:0]  acc_c;
  logic [ACC_W-1:0]         th_d, th_q, th;
  logic [AZIMUTH_WIDTH-1:0] phi1_q, phi;
  logic                     zero1_q;
  logic [ACC_W-1:0]         tol;
  logic [POLAR_WIDTH-1:0]   polar_q;
  logic [AZIMUTH_WIDTH-1:0] az_q;

  assign en2   = !v2_q || rdy_i;
  assign en1   = !v1_q || en2;
  assign rdy_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) v1_q <= vld_i;
      if (en2) v2_q <= v1_q;
    end
  end

  always_comb begin
    if (st_i.acc[ACC_W-1]) acc_c = '0;
    else if (st_i.acc > DEG180) acc_c = DEG180;
    else acc_c = st_i.acc;
    th_d = (ACC_W'(acc_c) + RND) >> SH;
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      th_q    <= th_d;
      phi1_q  <= sb_i.phi;
      zero1_q <= sb_i.zero;
    end
  end

  // zero vector reads as 90/90; pole test applies after that
  always_comb begin
    tol = ACC_W'(tol_i);
    th  = zero1_q ? QUARTER : th_q;
    phi = zero1_q ? AZIMUTH_WIDTH'(QUARTER) : phi1_q;
    if ((th < tol) || ((HALF - th) < tol)) phi = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      polar_q <= POLAR_WIDTH'(th);
      az_q    <= phi;
    end
  end

  assign vld_o     = v2_q;
  assign polar_o   = polar_q;
  assign azimuth_o = az_q;

endmodule
`default_nettype wire

// ----- src/cartesian_to_polar_angles.sv -----
`timescale 1ns / 1ps
// Pipeline: normalize, then the azimuth and polar vectoring passes, with gain and azimuth
// rounding between them, then finish.
// Throughput: one vector per cycle while the output is not stalled; each pipeline stage
// holds its beat on backpressure.
// Reset: pipeline valids cleared, pole_tolerance reset to 1 output unit.
`default_nettype none
module cartesian_to_polar_angles #(
  parameter int COMPONENT_WIDTH = c2pa_pkg::COMPONENT_WIDTH_DEF,
  parameter int ANGLE_FRAC_BITS = c2pa_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STAGES   = c2pa_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  c2pa_vec_if.sink   vec_if,
  c2pa_res_if.source res_if,
  c2pa_cfg_if.sink   cfg_if
);
  import c2pa_pkg::*;

  localparam int SB1_W = $bits(side_phi_t);
  localparam int SB2_W = $bits(side_theta_t);

  logic [TOL_W-1:0] tol_q;

  cordic_t          pst [CORDIC_STAGES+1];
  logic [SB1_W-1:0] psb [CORDIC_STAGES+1];
  logic             pvld [CORDIC_STAGES+1];
  logic             prdy [CORDIC_STAGES+1];

  cordic_t          tst [CORDIC_STAGES+1];
  logic [SB2_W-1:0] tsb [CORDIC_STAGES+1];
  logic             tvld [CORDIC_STAGES+1];
  logic             trdy [CORDIC_STAGES+1];

  side_phi_t   sb_norm;
  side_theta_t sb_gain;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_W'(1);
    end else if (cfg_if.valid) begin
      tol_q <= cfg_if.pole_tolerance;
    end
  end

  c2pa_norm #(.CW(COMPONENT_WIDTH)) u_norm (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vld_i (vec_if.valid),
    .rdy_o (vec_if.ready),
    .x_i   (vec_if.vec_x),
    .y_i   (vec_if.vec_y),
    .z_i   (vec_if.vec_z),
    .vld_o (pvld[0]),
    .rdy_i (prdy[0]),
    .st_o  (pst[0]),
    .sb_o  (sb_norm)
  );
  assign psb[0] = sb_norm;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_phi
    c2pa_cordic_stage #(.IDX(i), .SB_W(SB1_W)) u_stage (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .vld_i (pvld[i]),
      .rdy_o (prdy[i]),
      .st_i  (pst[i]),
      .sb_i  (psb[i]),
      .vld_o (pvld[i+1]),
      .rdy_i (prdy[i+1]),
      .st_o  (pst[i+1]),
      .sb_o  (psb[i+1])
    );
  end

  c2pa_gain #(.AFB(ANGLE_FRAC_BITS)) u_gain (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vld_i (pvld[CORDIC_STAGES]),
    .rdy_o (prdy[CORDIC_STAGES]),
    .st_i  (pst[CORDIC_STAGES]),
    .sb_i  (side_phi_t'(psb[CORDIC_STAGES])),
    .vld_o (tvld[0]),
    .rdy_i (trdy[0]),
    .st_o  (tst[0]),
    .sb_o  (sb_gain)
  );
  assign tsb[0] = sb_gain;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_theta
    c2pa_cordic_stage #(.IDX(i), .SB_W(SB2_W)) u_stage (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .vld_i (tvld[i]),
      .rdy_o (trdy[i]),
      .st_i  (tst[i]),
      .sb_i  (tsb[i]),
      .vld_o (tvld[i+1]),
      .rdy_i (trdy[i+1]),
      .st_o  (tst[i+1]),
      .sb_o  (tsb[i+1])
    );
  end

  c2pa_finish #(.AFB(ANGLE_FRAC_BITS)) u_finish (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vld_i    (tvld[CORDIC_STAGES]),
    .rdy_o    (trdy[CORDIC_STAGES]),
    .st_i     (tst[CORDIC_STAGES]),
    .sb_i     (side_theta_t'(tsb[CORDIC_STAGES])),
    .tol_i    (tol_q),
    .vld_o    (res_if.valid),
    .rdy_i    (res_if.ready),
    .polar_o  (res_if.polar_angle),
    .azimuth_o(res_if.azimuth_angle)
  );

endmodule
`default_nettype wire

// ----- test/c2pa_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module c2pa_checker (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  c2pa_vec_if.sink   vec_if,
  c2pa_res_if.sink   res_if,
  c2pa_cfg_if.sink   cfg_if,
  output int         fail_cnt_o,
  output int         pending_o
);
  import c2pa_pkg::*;

  typedef struct packed {
    logic [POLAR_WIDTH-1:0]   theta;
    logic [AZIMUTH_WIDTH-1:0] phi;
  } angles_t;

  angles_t             angle_q[$];
  logic [TOL_W-1:0]    tol;

  function automatic logic signed [63:0] atan_ent(input int i);
    logic signed [63:0] tab [0:19];
    tab = '{754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
            15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684,
            117342, 58671, 29335, 14668, 7334, 3667, 1833};
    return tab[i];
  endfunction

  // drive b to zero, return angle rotated out; a holds the magnitude
  function automatic logic signed [63:0] rotate_out(inout logic signed [63:0] a,
                                                    inout logic signed [63:0] b,
                                                    input logic signed [63:0] acc);
    logic signed [63:0] da, db;
    for (int i = 0; i < 20; i++) begin
      da = b >>> i;
      db = a >>> i;
      if (b > 0) begin
        a = a + da; b = b - db; acc = acc + atan_ent(i);
      end else begin
        a = a - da; b = b + db; acc = acc - atan_ent(i);
      end
    end
    return acc;
  endfunction

  function automatic angles_t predict_angles(input logic signed [31:0] vx,
                                             input logic signed [31:0] vy,
                                             input logic signed [31:0] vz,
                                             input logic [TOL_W-1:0] t);
    logic [63:0] mx, my, mz, m, mag, r, th, ph;
    logic signed [63:0] x, y, z, a, b, acc;
    int s;
    angles_t res;
    mx = vx[31] ? 64'(-{{32{vx[31]}}, vx}) : 64'(vx);
    my = vy[31] ? 64'(-{{32{vy[31]}}, vy}) : 64'(vy);
    mz = vz[31] ? 64'(-{{32{vz[31]}}, vz}) : 64'(vz);
    m = mx;
    if (my > m) m = my;
    if (mz > m) m = mz;
    if (m == 0) begin
      th = 90 << 8;
      ph = 90 << 8;
    end else begin
      s = 0;
      while ((m << s) < (64'd1 << 57)) s++;
      x = mx << s; if (vx[31]) x = -x;
      y = my << s; if (vy[31]) y = -y;
      z = mz << s; if (vz[31]) z = -z;
      acc = 0;
      if (x < 0) begin
        x = -x; y = -y; acc = 64'(DEG180);
      end
      acc = rotate_out(x, y, acc);
      if (acc < 0) acc = acc + 64'(DEG360);
      ph = (acc + 64'd32768) >> 16;
      if (ph >= (360 << 8)) ph = 0;
      if (mx == 0 && my == 0) ph = 0;
      mag = x;
      r = (mag >> 30) * INV_GAIN + (((mag & 64'h3FFF_FFFF) * INV_GAIN) >> 30);
      if (z < 0) begin
        a = r; b = -z; acc = 64'(DEG90);
      end else begin
        a = z; b = r; acc = 0;
      end
      acc = rotate_out(a, b, acc);
      if (acc < 0) acc = 0;
      if (acc > 64'(DEG180)) acc = 64'(DEG180);
      th = (acc + 64'd32768) >> 16;
    end
    if (th < t || ((180 << 8) - th) < t) ph = 0;
    res.theta = th[POLAR_WIDTH-1:0];
    res.phi = ph[AZIMUTH_WIDTH-1:0];
    return res;
  endfunction

  assign pending_o = angle_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    angles_t exp_a;
    if (!rst_ni) begin
      tol <= 8'd1;
      fail_cnt_o <= 0;
      angle_q.delete();
    end else begin
      if (cfg_if.valid && cfg_if.ready) tol <= cfg_if.pole_tolerance;
      if (vec_if.valid && vec_if.ready)
        angle_q.push_back(predict_angles(vec_if.vec_x, vec_if.vec_y, vec_if.vec_z, tol));
      if (res_if.valid && res_if.ready) begin
        if (angle_q.size() == 0) begin
          $display("%0t: result beat with none expected: theta %0d phi %0d", $time,
                   res_if.polar_angle, res_if.azimuth_angle);
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          exp_a = angle_q.pop_front();
          if (exp_a.theta !== res_if.polar_angle) begin
            $display("%0t: polar_angle expected %0d actual %0d", $time, exp_a.theta,
                     res_if.polar_angle);
            fail_cnt_o <= fail_cnt_o + 1;
          end else if (exp_a.phi !== res_if.azimuth_angle) begin
            $display("%0t: azimuth_angle expected %0d actual %0d", $time, exp_a.phi,
                     res_if.azimuth_angle);
            fail_cnt_o <= fail_cnt_o + 1;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import c2pa_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_cnt, pending;
  bit   idle_en = 1'b1;
  bit   hold_sink = 1'b0;

  c2pa_vec_if vec_if ();
  c2pa_res_if res_if ();
  c2pa_cfg_if cfg_if ();

  cartesian_to_polar_angles dut (
    .clk_i, .rst_ni, .vec_if(vec_if.sink), .res_if(res_if.source), .cfg_if(cfg_if.sink)
  );

  c2pa_checker chk (
    .clk_i, .rst_ni, .vec_if(vec_if.sink), .res_if(res_if.sink), .cfg_if(cfg_if.sink),
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  always #10 clk_i = ~clk_i;

  initial begin
    #20000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      res_if.ready <= !hold_sink && !(idle_en && $urandom_range(99) < 18);
    end
  end

  function automatic logic [31:0] rnd_comp();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($signed($urandom_range(40)) - 20);
      3: return 32'($signed($urandom_range(2000)) - 1000);
      4: return 32'd0;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_vec(input logic [31:0] x, y, z);
    while (idle_en && $urandom_range(99) < 18) begin
      vec_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    vec_if.valid <= 1'b1;
    vec_if.vec_x <= x;
    vec_if.vec_y <= y;
    vec_if.vec_z <= z;
    do @(posedge clk_i); while (!vec_if.ready);
  endtask

  task automatic drain();
    vec_if.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_tol(input logic [7:0] t);
    cfg_if.valid <= 1'b1;
    cfg_if.pole_tolerance <= t;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic directed_set();
    send_vec(0, 0, 0);
    send_vec(0, 0, 5);
    send_vec(0, 0, -5);
    send_vec(1, 0, 0);
    send_vec(-1, 0, 0);
    send_vec(0, 1, 0);
    send_vec(0, -1, 0);
    send_vec(-1, -1, 0);
    send_vec(-1, 1, 0);
    send_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vec(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_vec(32'h7FFF_FFFF, 32'h8000_0000, 0);
    send_vec(1, 0, 32'h7FFF_FFFF);
    send_vec(1, 1, 32'h8000_0000);
    send_vec(32'h8000_0000, -1, 0);
    send_vec(1000, -1, 0);
    send_vec(-1000, 1, 3);
    send_vec(3, 4, 1);
    send_vec(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  initial begin
    logic [7:0] tols [5];
    tols = '{8'd0, 8'd255, 8'd1, 8'd128, 8'($urandom)};
    vec_if.valid = 1'b0;
    vec_if.vec_x = '0;
    vec_if.vec_y = '0;
    vec_if.vec_z = '0;
    cfg_if.valid = 1'b0;
    cfg_if.pole_tolerance = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_set();
    drain();
    for (int ph = 0; ph < 5; ph++) begin
      set_tol(tols[ph]);
      directed_set();
      if (ph == 1) begin
        // back-pressure: outputs held while inputs keep coming
        fork
          begin
            hold_sink = 1'b1;
            repeat (120) @(posedge clk_i);
            hold_sink = 1'b0;
          end
          begin
            repeat (60) send_vec(rnd_comp(), rnd_comp(), rnd_comp());
            vec_if.valid <= 1'b0;
          end
        join
      end
      idle_en = (ph != 2);
      for (int i = 0; i < 200; i++) send_vec(rnd_comp(), rnd_comp(), rnd_comp());
      idle_en = 1'b1;
      drain();
    end

    if (fail_cnt == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- sim.f -----
src/c2pa_pkg.sv
src/c2pa_if.sv
src/c2pa_norm.sv
src/c2pa_cordic_stage.sv
src/c2pa_gain.sv
src/c2pa_finish.sv
src/cartesian_to_polar_angles.sv
test/c2pa_checker.sv
test/tb.sv
